// ===== sv/trc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_pkg
// Shared constants, command and register codes and symbol helpers for the
// three-rotor reflecting cipher.
// ----------------------------------------------------------------------------
package trc_pkg;

    localparam int SYMBOLS   = 62;
    localparam int ROTORS    = 3;
    localparam int MEM_DEPTH = ROTORS * SYMBOLS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int SYM_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int CMD_W     = 2;
    localparam int SEL_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 6;
    localparam int STEP_W    = 2;

    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [MEM_AW-1:0] t_addr;
    typedef logic [SEL_W-1:0]  t_sel;
    typedef logic [STEP_W-1:0] t_step;

    // request commands
    localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_THREE = 2'd2;

    localparam t_sym  LAST_SYM  = t_sym'(SYMBOLS - 1);
    localparam t_step STEP_DONE = t_step'(ROTORS);

    localparam t_char CH_LOWER_A = 8'h61;
    localparam t_char CH_LOWER_Z = 8'h7a;
    localparam t_char CH_UPPER_A = 8'h41;
    localparam t_char CH_UPPER_Z = 8'h5a;
    localparam t_char CH_DIGIT_0 = 8'h30;
    localparam t_char CH_DIGIT_9 = 8'h39;

    localparam int UPPER_BASE = 26;
    localparam int DIGIT_BASE = 52;

    function automatic logic is_alnum(input t_char c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
    endfunction

    function automatic t_sym to_symbol(input t_char c);
        t_char k;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            k = c - CH_LOWER_A;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            k = c - CH_UPPER_A + t_char'(UPPER_BASE);
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            k = c - CH_DIGIT_0 + t_char'(DIGIT_BASE);
        end else begin
            k = '0;
        end
        return k[SYM_W-1:0];
    endfunction

    function automatic t_char to_char(input t_sym k);
        t_char kw;
        kw = {{(CHAR_W-SYM_W){1'b0}}, k};
        if (kw < t_char'(UPPER_BASE)) begin
            return CH_LOWER_A + kw;
        end else if (kw < t_char'(DIGIT_BASE)) begin
            return CH_UPPER_A + kw - t_char'(UPPER_BASE);
        end else begin
            return CH_DIGIT_0 + kw - t_char'(DIGIT_BASE);
        end
    endfunction

    // (k - off) mod SYMBOLS, both below SYMBOLS
    function automatic t_sym sub_mod(input t_sym k, input t_sym off);
        logic [SYM_W:0] d;
        d = {1'b0, k} + (SYM_W+1)'(SYMBOLS) - {1'b0, off};
        if (d >= (SYM_W+1)'(SYMBOLS)) begin
            d = d - (SYM_W+1)'(SYMBOLS);
        end
        return d[SYM_W-1:0];
    endfunction

    function automatic t_sym add_mod(input t_sym a, input t_sym b);
        logic [SYM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SYM_W+1)'(SYMBOLS)) begin
            s = s - (SYM_W+1)'(SYMBOLS);
        end
        return s[SYM_W-1:0];
    endfunction

    function automatic t_sym inc_mod(input t_sym a);
        return (a == LAST_SYM) ? '0 : a + t_sym'(1);
    endfunction

    // reduce a 6-bit value below SYMBOLS
    function automatic t_sym fold_sym(input t_sym a);
        return (a > LAST_SYM) ? a - t_sym'(SYMBOLS) : a;
    endfunction

    function automatic t_addr rotor_base(input t_step r);
        t_addr b;
        case (r)
            2'd0:    b = '0;
            2'd1:    b = t_addr'(SYMBOLS);
            default: b = t_addr'(2 * SYMBOLS);
        endcase
        return b;
    endfunction

endpackage

// ===== sv/trc_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc channels
// Valid/ready channel interfaces for cipher requests and results.
// ----------------------------------------------------------------------------
interface trc_req_if;
    logic                          valid;
    logic                          ready;
    logic [trc_pkg::CMD_W-1:0]     cmd;
    logic [trc_pkg::SEL_W-1:0]     rotor_select;
    logic [trc_pkg::SYM_W-1:0]     wire_index;
    logic [trc_pkg::SYM_W-1:0]     wire_value;
    logic [trc_pkg::CHAR_W-1:0]    char_in;

    modport source (output valid, cmd, rotor_select, wire_index, wire_value, char_in,
                    input ready);
    modport sink   (input valid, cmd, rotor_select, wire_index, wire_value, char_in,
                    output ready);
endinterface

interface trc_res_if;
    logic                          valid;
    logic                          ready;
    logic [trc_pkg::CHAR_W-1:0]    char_out;
    logic                          was_alphabetic;

    modport source (output valid, char_out, was_alphabetic, input ready);
    modport sink   (input valid, char_out, was_alphabetic, output ready);
endinterface

// ===== sv/three_rotor_reflector_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_rotor_reflector_cipher
// Self-inverse three-rotor cipher over a 62-symbol alphabet, with wiring and
// inverse tables held in two synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_req_ch  in   valid/ready    cmd, rotor_select, wire_index, wire_value, char_in
//  o_res_ch  out  valid/ready    char_out, was_alphabetic
//  cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data
//
//  A character request passes the forward stage, back stage and result register;
//  a new request is taken as soon as the forward stage is free. Each stage
//  makes three dependent reads of its table RAM (forward stage on the wiring RAM,
//  back stage on the inverse RAM). A wiring load holds the forward stage until
//  the back stage has issued its last read. Reset clears offsets, count and
//  control; the tables are not cleared. A stalled result holds the back stage.
// ----------------------------------------------------------------------------
module three_rotor_reflector_cipher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    trc_req_if.sink                          i_req_ch,
    trc_res_if.source                        o_res_ch,
    input  logic                             i_cfg_we,
    input  logic [trc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [trc_pkg::CFG_W-1:0]        i_cfg_data
);

    // tables
    trc_pkg::t_sym  r_wire_mem [trc_pkg::MEM_DEPTH];
    trc_pkg::t_sym  r_inv_mem  [trc_pkg::MEM_DEPTH];
    trc_pkg::t_sym  r_wire_rd;
    trc_pkg::t_sym  r_inv_rd;

    // configuration and rotor state
    trc_pkg::t_sym  r_start_off [trc_pkg::ROTORS];
    trc_pkg::t_sym  r_off       [trc_pkg::ROTORS];
    trc_pkg::t_sym  n_off       [trc_pkg::ROTORS];
    trc_pkg::t_sym  r_cnt_lo, n_cnt_lo;
    trc_pkg::t_sym  r_cnt_hi, n_cnt_hi;

    // forward stage
    logic           r_f_busy;
    logic           r_f_load;
    trc_pkg::t_step r_f_step;
    trc_pkg::t_sym  r_f_k;
    trc_pkg::t_sym  r_f_off [trc_pkg::ROTORS];
    logic           r_f_alpha;
    trc_pkg::t_char r_f_char;
    trc_pkg::t_step r_f_sel;
    trc_pkg::t_sym  r_f_idx;
    trc_pkg::t_sym  r_f_val;

    // back stage
    logic           r_b_busy;
    trc_pkg::t_step r_b_step;
    trc_pkg::t_sym  r_b_k;
    trc_pkg::t_sym  r_b_off [trc_pkg::ROTORS];
    logic           r_b_alpha;
    trc_pkg::t_char r_b_char;

    // result register
    logic           r_o_valid;
    trc_pkg::t_char r_o_char;
    logic           r_o_alpha;

    logic           o_free, b_done, b_free, f_handoff, f_write, f_free;
    logic           req_acc, req_char, req_load, req_start, load_ok, in_alpha;
    logic           wire_rd_en, inv_rd_en;
    trc_pkg::t_sym  f_src, f_off, b_prev_off, b_k_now;
    trc_pkg::t_step b_rotor;
    trc_pkg::t_addr wire_addr, inv_addr, wire_wr_addr, inv_wr_addr;
    logic           step_two, step_three;

    // handshake
    assign o_free    = !r_o_valid || o_res_ch.ready;
    assign b_done    = r_b_busy && (r_b_step == trc_pkg::STEP_DONE) && o_free;
    assign b_free    = !r_b_busy || b_done;
    assign f_handoff = r_f_busy && !r_f_load && (r_f_step == trc_pkg::STEP_DONE) && b_free;
    assign f_write   = r_f_busy && r_f_load &&
                       (!r_b_busy || r_b_step == trc_pkg::STEP_DONE);
    assign f_free    = !r_f_busy || f_handoff || f_write;

    assign i_req_ch.ready = f_free;
    assign req_acc        = i_req_ch.valid && f_free;

    assign load_ok = (i_req_ch.rotor_select < trc_pkg::SEL_W'(trc_pkg::ROTORS)) &&
                     (i_req_ch.wire_index <= trc_pkg::LAST_SYM) &&
                     (i_req_ch.wire_value <= trc_pkg::LAST_SYM);
    assign in_alpha = trc_pkg::is_alnum(i_req_ch.char_in);

    always_comb begin
        req_char  = 1'b0;
        req_load  = 1'b0;
        req_start = 1'b0;
        unique case (i_req_ch.cmd)
            trc_pkg::CMD_CHAR:  req_char  = req_acc;
            trc_pkg::CMD_LOAD:  req_load  = req_acc && load_ok;
            trc_pkg::CMD_START: req_start = req_acc;
            default: ;
        endcase
    end

    // rotor stepping
    always_comb begin
        n_cnt_lo = r_cnt_lo;
        n_cnt_hi = r_cnt_hi;
        n_off    = r_off;
        if (in_alpha) begin
            n_cnt_lo = trc_pkg::inc_mod(r_cnt_lo);
            if (r_cnt_lo == trc_pkg::LAST_SYM) begin
                n_cnt_hi = trc_pkg::inc_mod(r_cnt_hi);
            end
        end
        step_two   = (n_cnt_lo == '0);
        step_three = step_two && (n_cnt_hi == '0);
        n_off[0] = trc_pkg::inc_mod(r_off[0]);
        if (step_two) begin
            n_off[1] = trc_pkg::inc_mod(r_off[1]);
        end
        if (step_three) begin
            n_off[2] = trc_pkg::inc_mod(r_off[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_off <= '{default: '0};
            r_off       <= '{default: '0};
            r_cnt_lo    <= '0;
            r_cnt_hi    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    trc_pkg::CFG_START_ONE:   r_start_off[0] <= i_cfg_data;
                    trc_pkg::CFG_START_TWO:   r_start_off[1] <= i_cfg_data;
                    trc_pkg::CFG_START_THREE: r_start_off[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (req_start) begin
                for (int r = 0; r < trc_pkg::ROTORS; r++) begin
                    r_off[r] <= trc_pkg::fold_sym(r_start_off[r]);
                end
                r_cnt_lo <= '0;
                r_cnt_hi <= '0;
            end else if (req_char) begin
                r_off    <= n_off;
                r_cnt_lo <= n_cnt_lo;
                r_cnt_hi <= n_cnt_hi;
            end
        end
    end

    // forward stage: wiring reads, rotors one to three
    always_comb begin
        case (r_f_step)
            2'd0:    f_off = r_f_off[0];
            2'd1:    f_off = r_f_off[1];
            default: f_off = r_f_off[2];
        endcase
    end

    assign f_src      = (r_f_step == '0) ? r_f_k : r_wire_rd;
    assign wire_rd_en = r_f_busy && !r_f_load && (r_f_step != trc_pkg::STEP_DONE);
    assign wire_addr  = trc_pkg::rotor_base(r_f_step) +
                        trc_pkg::MEM_AW'(trc_pkg::sub_mod(f_src, f_off));

    // back stage: inverse reads, rotors three to one
    always_comb begin
        case (r_b_step)
            2'd0:    b_rotor = 2'd2;
            2'd1:    b_rotor = 2'd1;
            default: b_rotor = 2'd0;
        endcase
        case (r_b_step)
            2'd1:    b_prev_off = r_b_off[2];
            2'd2:    b_prev_off = r_b_off[1];
            default: b_prev_off = r_b_off[0];
        endcase
    end

    assign b_k_now   = (r_b_step == '0) ? r_b_k : trc_pkg::add_mod(r_inv_rd, b_prev_off);
    assign inv_rd_en = r_b_busy && (r_b_step != trc_pkg::STEP_DONE);
    assign inv_addr  = trc_pkg::rotor_base(b_rotor) + trc_pkg::MEM_AW'(b_k_now);

    assign wire_wr_addr = trc_pkg::rotor_base(r_f_sel) + trc_pkg::MEM_AW'(r_f_idx);
    assign inv_wr_addr  = trc_pkg::rotor_base(r_f_sel) + trc_pkg::MEM_AW'(r_f_val);

    // table RAMs
    always_ff @(posedge i_clk) begin
        if (f_write) begin
            r_wire_mem[wire_wr_addr] <= r_f_val;
        end
        if (wire_rd_en) begin
            r_wire_rd <= r_wire_mem[wire_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_write) begin
            r_inv_mem[inv_wr_addr] <= r_f_idx;
        end
        if (inv_rd_en) begin
            r_inv_rd <= r_inv_mem[inv_addr];
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_busy  <= 1'b0;
            r_f_load  <= 1'b0;
            r_f_step  <= '0;
            r_b_busy  <= 1'b0;
            r_b_step  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (req_char || req_load) begin
                r_f_busy <= 1'b1;
                r_f_load <= req_load;
                r_f_step <= '0;
            end else if (f_handoff || f_write) begin
                r_f_busy <= 1'b0;
            end else if (wire_rd_en) begin
                r_f_step <= r_f_step + trc_pkg::t_step'(1);
            end

            if (f_handoff) begin
                r_b_busy <= 1'b1;
                r_b_step <= '0;
            end else if (b_done) begin
                r_b_busy <= 1'b0;
            end else if (inv_rd_en) begin
                r_b_step <= r_b_step + trc_pkg::t_step'(1);
            end

            if (b_done) begin
                r_o_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (req_char || req_load) begin
            r_f_k     <= trc_pkg::to_symbol(i_req_ch.char_in);
            r_f_off   <= r_off;
            r_f_alpha <= in_alpha;
            r_f_char  <= i_req_ch.char_in;
            r_f_sel   <= i_req_ch.rotor_select;
            r_f_idx   <= i_req_ch.wire_index;
            r_f_val   <= i_req_ch.wire_value;
        end
        if (f_handoff) begin
            r_b_k     <= trc_pkg::LAST_SYM - r_wire_rd;
            r_b_off   <= r_f_off;
            r_b_alpha <= r_f_alpha;
            r_b_char  <= r_f_char;
        end
        if (b_done) begin
            r_o_char  <= r_b_alpha ? trc_pkg::to_char(b_k_now) : r_b_char;
            r_o_alpha <= r_b_alpha;
        end
    end

    assign o_res_ch.valid          = r_o_valid;
    assign o_res_ch.char_out       = r_o_char;
    assign o_res_ch.was_alphabetic = r_o_alpha;

endmodule

// ===== sv/trc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_checker
// Port-level checks on the cipher: idle after reset, result holding, class and count in flight.
// ----------------------------------------------------------------------------
module trc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic [trc_pkg::CMD_W-1:0]     i_req_cmd,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [trc_pkg::CHAR_W-1:0]    i_res_char,
    input logic                          i_res_alpha
);

    logic [2:0] r_pend;
    logic [2:0] n_pend;

    // character requests taken but not yet delivered
    always_comb begin
        n_pend = r_pend;
        if (i_req_valid && i_req_ready && i_req_cmd == trc_pkg::CMD_CHAR) begin
            n_pend = n_pend + 3'd1;
        end
        if (i_res_valid && i_res_ready) begin
            n_pend = n_pend - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid straight after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_char) && $stable(i_res_alpha))
        else $error("stalled result changed");

    a_res_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_alpha == trc_pkg::is_alnum(i_res_char))
        else $error("result class does not match its byte");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> r_pend != 3'd0)
        else $error("result without a character request");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd3)
        else $error("more characters in flight than stages");

endmodule

bind three_rotor_reflector_cipher trc_checker u_trc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_ch.valid),
    .i_req_ready (i_req_ch.ready),
    .i_req_cmd   (i_req_ch.cmd),
    .i_res_valid (o_res_ch.valid),
    .i_res_ready (o_res_ch.ready),
    .i_res_char  (o_res_ch.char_out),
    .i_res_alpha (o_res_ch.was_alphabetic)
);

// ===== sim/three_rotor_reflector_cipher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_rotor_reflector_cipher_test
// Self-checking bench for the three-rotor cipher. All three rotors are first
// loaded with full permutations, then directed and random requests run over
// several start offsets, including a message long enough to step rotor two
// more than once. A rotor model predicts every result; idling, a long result
// hold-off and drains between phases exercise the handshakes.
// ----------------------------------------------------------------------------
module three_rotor_reflector_cipher_test;
    import trc_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam t_sel                 NO_ROTOR   = 2'd3;

    localparam int COUNT_WRAP         = SYMBOLS * SYMBOLS;
    localparam int SETTLE_CYCLES      = 16;
    localparam int RESULT_HOLD_CYCLES = 150;
    localparam int STALL_LIMIT        = 2000;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        t_sel             rotor_select;
        t_sym             wire_index;
        t_sym             wire_value;
        t_char            char_in;
    } t_cipher_request;

    typedef struct {
        t_char char_out;
        logic  was_alphabetic;
    } t_cipher_result;

    class rotor_cipher_model;
        t_sym           wiring [ROTORS][SYMBOLS];
        t_sym           inverse [ROTORS][SYMBOLS];
        t_sym           offsets [ROTORS];
        t_sym           start_offsets [ROTORS];
        int unsigned    alpha_count;
        t_cipher_result expected_results [$];
        int unsigned    mismatches;

        function new();
            foreach (offsets[r]) begin
                offsets[r]       = '0;
                start_offsets[r] = '0;
            end
            alpha_count = 0;
            mismatches  = 0;
        endfunction

        static function int byte_symbol(t_char c);
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c - CH_LOWER_A);
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c - CH_UPPER_A) + UPPER_BASE;
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return int'(c - CH_DIGIT_0) + DIGIT_BASE;
            return -1;
        endfunction

        static function t_char symbol_byte(int k);
            if (k < UPPER_BASE) return t_char'(CH_LOWER_A + k);
            if (k < DIGIT_BASE) return t_char'(CH_UPPER_A + k - UPPER_BASE);
            return t_char'(CH_DIGIT_0 + k - DIGIT_BASE);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx < ROTORS) start_offsets[idx] = data;
        endfunction

        function void note_request(t_cipher_request req);
            t_cipher_result res;
            int             k;
            int             r;
            case (req.cmd)
                CMD_LOAD: begin
                    if (req.rotor_select < ROTORS && req.wire_index < SYMBOLS &&
                        req.wire_value < SYMBOLS) begin
                        wiring[req.rotor_select][req.wire_index]  = req.wire_value;
                        inverse[req.rotor_select][req.wire_value] = req.wire_index;
                    end
                end
                CMD_START: begin
                    for (r = 0; r < ROTORS; r++) offsets[r] = start_offsets[r] % SYMBOLS;
                    alpha_count = 0;
                end
                CMD_CHAR: begin
                    k                  = byte_symbol(req.char_in);
                    res.char_out       = req.char_in;
                    res.was_alphabetic = 1'b0;
                    if (k >= 0) begin
                        for (r = 0; r < ROTORS; r++) begin
                            k = wiring[r][(k + SYMBOLS - offsets[r]) % SYMBOLS];
                        end
                        k = SYMBOLS - 1 - k;
                        for (r = ROTORS - 1; r >= 0; r--) begin
                            k = (inverse[r][k] + offsets[r]) % SYMBOLS;
                        end
                        res.char_out       = symbol_byte(k);
                        res.was_alphabetic = 1'b1;
                        alpha_count        = (alpha_count + 1) % COUNT_WRAP;
                    end
                    offsets[0] = (offsets[0] + 1) % SYMBOLS;
                    if (alpha_count % SYMBOLS == 0) offsets[1] = (offsets[1] + 1) % SYMBOLS;
                    if (alpha_count == 0) offsets[2] = (offsets[2] + 1) % SYMBOLS;
                    expected_results.push_back(res);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(t_char c, logic alpha);
            t_cipher_result want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %02h with no request outstanding", c));
                return;
            end
            want = expected_results.pop_front();
            if (c !== want.char_out)
                report_mismatch($sformatf("char_out %02h, predicted %02h", c, want.char_out));
            if (alpha !== want.was_alphabetic)
                report_mismatch($sformatf("was_alphabetic %b, predicted %b",
                                          alpha, want.was_alphabetic));
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    bit                   hold_results = 1'b0;
    bit                   no_idling    = 1'b0;

    rotor_cipher_model cipher = new;

    trc_req_if req_ch ();
    trc_res_if res_ch ();

    three_rotor_reflector_cipher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_ch   (req_ch),
        .o_res_ch   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_cipher_request random_request();
        t_cipher_request req;
        req.cmd          = CMD_W'($urandom_range(0, 3));
        req.rotor_select = t_sel'($urandom_range(0, 3));
        req.wire_index   = t_sym'($urandom_range(0, 63));
        req.wire_value   = t_sym'($urandom_range(0, 63));
        req.char_in      = t_char'($urandom_range(0, 255));
        return req;
    endfunction

    task automatic send_request(t_cipher_request req, bit allow_gap);
        if (allow_gap && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= req.cmd;
        req_ch.rotor_select <= req.rotor_select;
        req_ch.wire_index   <= req.wire_index;
        req_ch.wire_value   <= req.wire_value;
        req_ch.char_in      <= req.char_in;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        cipher.note_request(req);
    endtask

    task automatic send_char(t_char c, bit allow_gap);
        t_cipher_request req;
        req         = random_request();
        req.cmd     = CMD_CHAR;
        req.char_in = c;
        send_request(req, allow_gap);
    endtask

    task automatic send_load(t_sel sel, t_sym idx, t_sym val, bit allow_gap);
        t_cipher_request req;
        req              = random_request();
        req.cmd          = CMD_LOAD;
        req.rotor_select = sel;
        req.wire_index   = idx;
        req.wire_value   = val;
        send_request(req, allow_gap);
    endtask

    task automatic send_command(logic [CMD_W-1:0] cmd, bit allow_gap);
        t_cipher_request req;
        req     = random_request();
        req.cmd = cmd;
        send_request(req, allow_gap);
    endtask

    task automatic send_random_item();
        t_cipher_request req;
        int unsigned     pick;
        pick = $urandom_range(0, 99);
        req  = random_request();
        if (pick < 70) begin
            req.cmd     = CMD_CHAR;
            req.char_in = rotor_cipher_model::symbol_byte($urandom_range(0, SYMBOLS - 1));
        end else if (pick < 84) begin
            req.cmd = CMD_CHAR;
        end else if (pick < 90) begin
            req.cmd          = CMD_LOAD;
            req.rotor_select = t_sel'($urandom_range(0, ROTORS - 1));
            req.wire_index   = t_sym'($urandom_range(0, SYMBOLS - 1));
            req.wire_value   = t_sym'($urandom_range(0, SYMBOLS - 1));
        end else if (pick < 93) begin
            req.cmd = CMD_LOAD;
            case ($urandom_range(0, 2))
                0:       req.rotor_select = NO_ROTOR;
                1:       req.wire_index   = t_sym'($urandom_range(SYMBOLS, 63));
                default: req.wire_value   = t_sym'($urandom_range(SYMBOLS, 63));
            endcase
        end else if (pick < 96) begin
            req.cmd = CMD_START;
        end else begin
            req.cmd = CMD_UNUSED;
        end
        send_request(req, !no_idling);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (cipher.pending() != 0) @(posedge i_clk);
    endtask

    // loads give no result, so allow the pipeline to empty after the last one
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        cipher.note_config(idx, data);
    endtask

    task automatic start_message(logic [CFG_W-1:0] one, logic [CFG_W-1:0] two,
                                 logic [CFG_W-1:0] three, bit touch_unused);
        settle();
        write_config(CFG_START_ONE, one);
        write_config(CFG_START_TWO, two);
        write_config(CFG_START_THREE, three);
        if (touch_unused) write_config(CFG_UNUSED, CFG_W'($urandom_range(0, 63)));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_command(CMD_START, !no_idling);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            cipher.check_result(res_ch.char_out, res_ch.was_alphabetic);
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                res_ch.ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end else if (!no_idling && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int    perm [SYMBOLS];
        int    sel;
        int    i;
        int    j;
        int    tmp;
        t_char c;
        t_char boundary_bytes [12];

        boundary_bytes = '{CH_LOWER_A, CH_LOWER_Z, CH_UPPER_A, CH_UPPER_Z,
                           CH_DIGIT_0, CH_DIGIT_9, CH_LOWER_A - 8'd1, CH_LOWER_Z + 8'd1,
                           CH_UPPER_A - 8'd1, CH_UPPER_Z + 8'd1,
                           CH_DIGIT_0 - 8'd1, CH_DIGIT_9 + 8'd1};
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_CHAR;
        req_ch.rotor_select = '0;
        req_ch.wire_index   = '0;
        req_ch.wire_value   = '0;
        req_ch.char_in      = '0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        i_rst_n             = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full permutations first, so no table entry is read before it is written
        for (sel = 0; sel < ROTORS; sel++) begin
            for (i = 0; i < SYMBOLS; i++) perm[i] = i;
            for (i = SYMBOLS - 1; i > 0; i--) begin
                j       = $urandom_range(0, i);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            for (i = 0; i < SYMBOLS; i++)
                send_load(t_sel'(sel), t_sym'(i), t_sym'(perm[i]), 1'b1);
        end

        // non-alphabetic bytes at count zero step all three rotors
        send_command(CMD_START, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
        foreach (boundary_bytes[n]) send_char(boundary_bytes[n], 1'b1);
        send_command(CMD_UNUSED, 1'b1);
        send_load(NO_ROTOR, t_sym'($urandom_range(0, SYMBOLS - 1)),
                  t_sym'($urandom_range(0, SYMBOLS - 1)), 1'b1);
        send_load(t_sel'(0), t_sym'(SYMBOLS), t_sym'(5), 1'b1);
        send_load(t_sel'(1), t_sym'(7), t_sym'(SYMBOLS + 1), 1'b1);
        send_load(t_sel'(2), LAST_SYM, '0, 1'b1);
        send_char(CH_DIGIT_9, 1'b1);
        send_char(CH_LOWER_A, 1'b1);

        repeat (300) send_random_item();

        start_message(LAST_SYM, LAST_SYM, LAST_SYM, 1'b1);
        hold_results = 1'b1;
        repeat (30) send_char(rotor_cipher_model::symbol_byte($urandom_range(0, SYMBOLS - 1)),
                              1'b0);
        drain();
        repeat (300) send_random_item();

        start_message(t_sym'(SYMBOLS), t_sym'(SYMBOLS + 1), '0, 1'b0);
        repeat (300) send_random_item();

        // long enough for rotor two to step twice within one message
        start_message(t_sym'($urandom_range(0, 63)), t_sym'($urandom_range(0, 63)),
                      t_sym'($urandom_range(0, 63)), 1'b0);
        repeat (2 * SYMBOLS + 5)
            send_char(rotor_cipher_model::symbol_byte($urandom_range(0, SYMBOLS - 1)), 1'b1);
        repeat (3) begin
            do c = t_char'($urandom_range(0, 255));
            while (rotor_cipher_model::byte_symbol(c) >= 0);
            send_char(c, 1'b1);
        end
        repeat (10)
            send_char(rotor_cipher_model::symbol_byte($urandom_range(0, SYMBOLS - 1)), 1'b1);

        start_message(t_sym'($urandom_range(0, 63)), t_sym'($urandom_range(0, 63)),
                      t_sym'($urandom_range(0, 63)), 1'b1);
        repeat (250) send_random_item();

        no_idling = 1'b1;
        start_message(t_sym'($urandom_range(0, 63)), t_sym'($urandom_range(0, 63)),
                      t_sym'($urandom_range(0, 63)), 1'b0);
        repeat (250) send_random_item();

        settle();
        if (cipher.pending() != 0)
            cipher.report_mismatch($sformatf("%0d results never arrived", cipher.pending()));
        if (cipher.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
